### design/mips_subset_execute_unit_core_defines.svh
// assertion macros shared by the execute unit
`ifndef MIPS_SUBSET_EXECUTE_UNIT_CORE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_CORE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define MSEU_ASSERT_NOW(name, clk, rstn, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (prop)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define MSEU_ASSERT_NEXT(name, clk, rstn, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
        else $error(msg);

`endif

### design/mseu_pkg.sv
package mseu_pkg;

    typedef enum logic [4:0] {
        F_ADD   = 5'd0,
        F_ADDU  = 5'd1,
        F_ADDI  = 5'd2,
        F_ADDIU = 5'd3,
        F_AND   = 5'd4,
        F_ANDI  = 5'd5,
        F_OR    = 5'd6,
        F_ORI   = 5'd7,
        F_SUB   = 5'd8,
        F_SUBU  = 5'd9,
        F_SLT   = 5'd10,
        F_SLTU  = 5'd11,
        F_SLTI  = 5'd12,
        F_SLTIU = 5'd13,
        F_SLL   = 5'd14,
        F_SRL   = 5'd15,
        F_LW    = 5'd16,
        F_SW    = 5'd17,
        F_BEQ   = 5'd18,
        F_BNE   = 5'd19,
        F_J     = 5'd20,
        F_JAL   = 5'd21,
        F_JR    = 5'd22
    } t_func;

    localparam int unsigned IN_W  = 96;
    localparam int unsigned OUT_W = 72;
    localparam logic [4:0]  LINK_REG = 5'd31;

    typedef struct packed {
        logic        v;
        logic        lw;
        logic        sw;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic [31:0] npc;
        logic        taken;
        logic [31:0] sdata;
    } t_slot;

endpackage

### design/mips_subset_execute_unit_core.sv
// Executes one decoded instruction per transaction and returns one result transaction for
// each, in order. Register file (32 words) and data memory (MEM_DEPTH words) are synchronous
// memories with registered reads. An instruction is accepted every cycle except while the
// result side holds off, or while the one before it has an rs or rt field naming a register
// still being loaded by an lw up to four instructions ahead of it; such a stall lasts until
// the load has come through the three-stage address reduction (byte residues, reciprocal
// multiply, correction) and the data memory read. After reset the data memory is swept to
// zero, and no input is taken during the sweep.
`include "mips_subset_execute_unit_core_defines.svh"

module mips_subset_execute_unit_core #(
    parameter int MEM_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // func, dest_index, src_a_index, src_b_index, immediate, shift_amount, current_pc
    input  logic [mseu_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // reg_written, written_index, written_value, next_pc, transfer_taken, store_done
    output logic [mseu_pkg::OUT_W-1:0]   m_axis_tdata
);
    import mseu_pkg::*;

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int YW  = 26;
    localparam int QW  = YW - AW + 1;
    localparam int SH  = YW + AW;
    localparam int PW  = 2 * YW + 1;
    localparam int NST = 5;

    localparam logic [63:0] DEP     = 64'(MEM_DEPTH);
    localparam logic [63:0] MAGIC64 = ((64'd1 << SH) + DEP - 64'd1) / DEP;
    localparam logic [63:0] RES1    = (64'd1 << 8) % DEP;
    localparam logic [63:0] RES2    = (64'd1 << 16) % DEP;
    localparam logic [63:0] RES3    = (64'd1 << 24) % DEP;

    localparam logic [YW-1:0] K1    = YW'(RES1);
    localparam logic [YW-1:0] K2    = YW'(RES2);
    localparam logic [YW-1:0] K3    = YW'(RES3);
    localparam logic [PW-1:0] MAGIC = PW'(MAGIC64);
    localparam logic [YW-1:0] DEP_Y = YW'(MEM_DEPTH);

    logic          adv;
    logic          stall_e;
    logic          in_fire;
    logic          hold_rd;

    logic          r_clr;
    logic [AW-1:0] r_clr_cnt;

    logic          r_s1_v;
    t_func         r_s1_func;
    logic [4:0]    r_s1_rd;
    logic [4:0]    r_s1_rs;
    logic [4:0]    r_s1_rt;
    logic [4:0]    r_s1_sh;
    logic [31:0]   r_s1_imm;
    logic [31:0]   r_s1_pc;

    logic [31:0]   r_rf [32];
    logic [31:0]   r_rf_vld;
    logic [31:0]   r_rf_a;
    logic [31:0]   r_rf_b;
    logic          r_rf_a_vld;
    logic          r_rf_b_vld;
    logic [4:0]    rd_a_idx;
    logic [4:0]    rd_b_idx;

    logic          r_ret_v;
    logic [4:0]    r_ret_idx;
    logic [31:0]   r_ret_val;

    t_slot         r_st [NST];
    t_slot         e_slot;

    logic [31:0]   op_a;
    logic [31:0]   op_b;
    logic          a_stall;
    logic          b_stall;
    logic [31:0]   e_sum;

    logic [31:0]   r_s2_sum;
    logic [YW-1:0] r_s3_y;
    logic [YW-1:0] r_s4_y;
    logic [QW-1:0] r_s4_q;
    logic [AW-1:0] r_s5_addr;
    logic [YW-1:0] a1_y;
    logic [PW-1:0] a2_prod;
    logic [YW-1:0] a3_rem;

    logic [31:0]   r_dmem [MEM_DEPTH];
    logic [31:0]   r_rdata;

    logic [31:0]   wb_val;
    logic          wb_we;

    logic          r_o_v;
    logic          r_o_wr;
    logic [4:0]    r_o_widx;
    logic [31:0]   r_o_wval;
    logic [31:0]   r_o_npc;
    logic          r_o_taken;
    logic          r_o_store;

    function automatic logic [7:0] s2_byte(input int unsigned idx);
        s2_byte = r_s2_sum[8*idx +: 8];
    endfunction

    assign adv           = !r_o_v || m_axis_tready;
    assign stall_e       = r_s1_v && (a_stall || b_stall);
    assign s_axis_tready = !r_clr && adv && !stall_e;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign hold_rd       = !adv || stall_e;

    assign rd_a_idx = hold_rd ? r_s1_rs : s_axis_tdata[14:10];
    assign rd_b_idx = hold_rd ? r_s1_rt : s_axis_tdata[19:15];

    assign wb_val = r_st[NST-1].lw ? r_rdata : r_st[NST-1].wval;
    assign wb_we  = adv && r_st[NST-1].v && r_st[NST-1].wr;

    // memory clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(MEM_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        r_rf_a     <= r_rf[rd_a_idx];
        r_rf_b     <= r_rf[rd_b_idx];
        r_rf_a_vld <= r_rf_vld[rd_a_idx];
        r_rf_b_vld <= r_rf_vld[rd_b_idx];
        if (wb_we) begin
            r_rf[r_st[NST-1].widx] <= wb_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_ret_v  <= 1'b0;
        end else begin
            if (wb_we) begin
                r_rf_vld[r_st[NST-1].widx] <= 1'b1;
            end
            r_ret_v <= wb_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret_idx <= r_st[NST-1].widx;
        r_ret_val <= wb_val;
    end

    // operand bypass, newest writer wins
    always_comb begin
        op_a    = r_rf_a_vld ? r_rf_a : '0;
        op_b    = r_rf_b_vld ? r_rf_b : '0;
        a_stall = 1'b0;
        b_stall = 1'b0;
        if (r_ret_v && r_ret_idx == r_s1_rs) begin
            op_a = r_ret_val;
        end
        if (r_ret_v && r_ret_idx == r_s1_rt) begin
            op_b = r_ret_val;
        end
        for (int k = NST - 1; k >= 0; k--) begin
            if (r_st[k].v && r_st[k].wr && r_st[k].widx == r_s1_rs) begin
                op_a    = (k == NST - 1) ? wb_val : r_st[k].wval;
                a_stall = r_st[k].lw && (k != NST - 1);
            end
            if (r_st[k].v && r_st[k].wr && r_st[k].widx == r_s1_rt) begin
                op_b    = (k == NST - 1) ? wb_val : r_st[k].wval;
                b_stall = r_st[k].lw && (k != NST - 1);
            end
        end
    end

    // execute
    always_comb begin
        e_slot       = '0;
        e_slot.v     = r_s1_v && !stall_e;
        e_slot.npc   = r_s1_pc;
        e_slot.sdata = op_b;
        e_sum        = op_a + r_s1_imm;
        unique case (r_s1_func) inside
            F_ADD, F_ADDU: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rd;
                e_slot.wval = op_a + op_b;
            end
            F_ADDI, F_ADDIU: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rt;
                e_slot.wval = e_sum;
            end
            F_AND: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rd;
                e_slot.wval = op_a & op_b;
            end
            F_ANDI: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rt;
                e_slot.wval = op_a & r_s1_imm;
            end
            F_OR: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rd;
                e_slot.wval = op_a | op_b;
            end
            F_ORI: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rt;
                e_slot.wval = op_a | r_s1_imm;
            end
            F_SUB, F_SUBU: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rd;
                e_slot.wval = op_a - op_b;
            end
            F_SLT: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rd;
                e_slot.wval = {31'd0, $signed(op_a) < $signed(op_b)};
            end
            F_SLTU: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rd;
                e_slot.wval = {31'd0, op_a < op_b};
            end
            F_SLTI: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rt;
                e_slot.wval = {31'd0, $signed(op_a) < $signed(r_s1_imm)};
            end
            F_SLTIU: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rt;
                e_slot.wval = {31'd0, op_a < r_s1_imm};
            end
            F_SLL: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rd;
                e_slot.wval = op_a << r_s1_sh;
            end
            F_SRL: begin
                e_slot.wr   = 1'b1;
                e_slot.widx = r_s1_rd;
                e_slot.wval = op_a >> r_s1_sh;
            end
            F_LW: begin
                e_slot.wr   = 1'b1;
                e_slot.lw   = 1'b1;
                e_slot.widx = r_s1_rt;
            end
            F_SW: begin
                e_slot.sw = 1'b1;
            end
            F_BEQ: begin
                if (op_a == op_b) begin
                    e_slot.npc   = r_s1_imm;
                    e_slot.taken = 1'b1;
                end
            end
            F_BNE: begin
                if (op_a != op_b) begin
                    e_slot.npc   = r_s1_imm;
                    e_slot.taken = 1'b1;
                end
            end
            F_J: begin
                e_slot.npc   = r_s1_imm;
                e_slot.taken = 1'b1;
            end
            F_JAL: begin
                e_slot.wr    = 1'b1;
                e_slot.widx  = LINK_REG;
                e_slot.wval  = r_s1_pc;
                e_slot.npc   = r_s1_imm;
                e_slot.taken = 1'b1;
            end
            F_JR: begin
                e_slot.npc   = op_a;
                e_slot.taken = 1'b1;
            end
            default: begin
            end
        endcase
        if (e_slot.wr && e_slot.widx == '0) begin
            e_slot.wr = 1'b0;
        end
        if (!e_slot.wr) begin
            e_slot.widx = '0;
            e_slot.wval = '0;
        end
    end

    // address reduction modulo memory depth
    assign a1_y = YW'(s2_byte(0)) + YW'(s2_byte(1)) * K1 + YW'(s2_byte(2)) * K2
                + YW'(s2_byte(3)) * K3;
    assign a2_prod = PW'(r_s3_y) * MAGIC;
    assign a3_rem  = r_s4_y - YW'(r_s4_q) * DEP_Y;

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            for (int k = 0; k < NST; k++) begin
                r_st[k].v <= 1'b0;
            end
        end else if (adv) begin
            if (!stall_e) begin
                r_s1_v <= in_fire;
            end
            r_st[0] <= e_slot;
            for (int k = 1; k < NST; k++) begin
                r_st[k] <= r_st[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && !stall_e) begin
            r_s1_func <= t_func'(s_axis_tdata[4:0]);
            r_s1_rd   <= s_axis_tdata[9:5];
            r_s1_rs   <= s_axis_tdata[14:10];
            r_s1_rt   <= s_axis_tdata[19:15];
            r_s1_imm  <= s_axis_tdata[51:20];
            r_s1_sh   <= s_axis_tdata[56:52];
            r_s1_pc   <= s_axis_tdata[88:57];
        end
        if (adv) begin
            r_s2_sum  <= e_sum;
            r_s3_y    <= a1_y;
            r_s4_y    <= r_s3_y;
            r_s4_q    <= a2_prod[SH +: QW];
            r_s5_addr <= a3_rem[AW-1:0];
        end
    end

    // data memory
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_dmem[r_clr_cnt] <= '0;
        end else if (adv && r_st[NST-2].v && r_st[NST-2].sw) begin
            r_dmem[r_s5_addr] <= r_st[NST-2].sdata;
        end
        if (adv) begin
            r_rdata <= r_dmem[r_s5_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (adv) begin
            r_o_v <= r_st[NST-1].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_wr    <= r_st[NST-1].wr;
            r_o_widx  <= r_st[NST-1].widx;
            r_o_wval  <= r_st[NST-1].wr ? wb_val : '0;
            r_o_npc   <= r_st[NST-1].npc;
            r_o_taken <= r_st[NST-1].taken;
            r_o_store <= r_st[NST-1].sw;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {r_o_store, r_o_taken, r_o_npc, r_o_wval, r_o_widx, r_o_wr};

    `MSEU_ASSERT_NOW(a_clear_blocks_input, i_clk, i_rst_n, r_clr, !s_axis_tready,
        "input taken during memory clearing")
    `MSEU_ASSERT_NOW(a_no_zero_write, i_clk, i_rst_n, wb_we, r_st[NST-1].widx != 5'd0,
        "register zero written")
    `MSEU_ASSERT_NOW(a_stall_from_load, i_clk, i_rst_n, stall_e,
        r_st[0].lw || r_st[1].lw || r_st[2].lw || r_st[3].lw,
        "interlock without a load in flight")
    `MSEU_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, adv && stall_e,
        r_s1_v && $stable(r_s1_pc) && $stable(r_s1_func),
        "stalled instruction lost")

endmodule
